// ===== sv/premultiplied_pixel_blender_core_macros.svh =====
// assertion helpers shared by the blender rtl
`ifndef PREMULTIPLIED_PIXEL_BLENDER_CORE_MACROS_SVH
`define PREMULTIPLIED_PIXEL_BLENDER_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PPB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PPB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ppb_pkg.sv =====
package ppb_pkg;

   localparam int STAGES   = 4;
   localparam int CHANNELS = 4;
   localparam int CHAN_W   = 8;
   localparam int PIXEL_W  = CHANNELS * CHAN_W;
   localparam int PROD_W   = 2 * CHAN_W;
   localparam int ALPHA    = 3;

   localparam logic [1:0] MODE_SOLID  = 2'd0;
   localparam logic [1:0] MODE_IMAGE  = 2'd1;
   localparam logic [1:0] MODE_OPAQUE = 2'd2;

   localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hFF;
   localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hFF00_0000;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [STAGES-1:0] valid;
   } pipe_ctl_type;

   // exact rounded v / 255 for v up to 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] v);
      logic [PROD_W:0] t;
      logic [PROD_W:0] u;
      t = {1'b0, v} + (PROD_W + 1)'(128);
      u = t + (t >> CHAN_W);
      return u[PROD_W-1:CHAN_W];
   endfunction

endpackage

// ===== sv/ppb_req_if.sv =====
interface ppb_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  mode;
   logic [ppb_pkg::PIXEL_W-1:0] dst_pixel;
   logic [ppb_pkg::PIXEL_W-1:0] src_pixel;

   modport source (output valid, mode, dst_pixel, src_pixel, input ready);
   modport sink   (input valid, mode, dst_pixel, src_pixel, output ready);
endinterface

// ===== sv/ppb_rsp_if.sv =====
interface ppb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ppb_pkg::PIXEL_W-1:0] out_pixel;

   modport source (output valid, out_pixel, input ready);
   modport sink   (input valid, out_pixel, output ready);
endinterface

// ===== sv/premultiplied_pixel_blender_core.sv =====
// a req beat is registered in each stage in turn, and its rsp is offered from the last stage
// throughput: one pixel per clock while rsp is not stalled; four register stages (source multiply,
//    source divide, destination multiply, destination divide and add) each hold one beat
// a stalled rsp backs up the stages one by one, bubbles ahead of it still fill
// reset (synchronous, active high) clears all stage valid bits and sets opacity to 255
`include "premultiplied_pixel_blender_core_macros.svh"

module premultiplied_pixel_blender_core (
   input  logic                          clock,
   input  logic                          reset,
   ppb_req_if.sink                       req,
   ppb_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [ppb_pkg::CHAN_W-1:0]    csr_wdata
);

   localparam int CW = ppb_pkg::CHAN_W;
   localparam int PW = ppb_pkg::PIXEL_W;
   localparam int NC = ppb_pkg::CHANNELS;
   localparam int MW = ppb_pkg::PROD_W;
   localparam int AI = ppb_pkg::ALPHA;

   ppb_pkg::pipe_ctl_type ctl;

   logic [CW-1:0] opacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= ppb_pkg::CHAN_MAX;
      end else if (csr_we) begin
         opacity_ff <= csr_wdata;
      end
   end

   ppb_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .out_ready (rsp.ready),
      .in_ready  (req.ready),
      .ctl       (ctl)
   );

   // stage 1: source channels times alpha (solid) or opacity (image)
   logic [NC-1:0][MW-1:0] prod1_in, prod1_ff;
   logic [CW-1:0]         a1_ff;
   logic [PW-1:0]         dst1_ff;
   logic                  image1_in, image1_ff;
   logic                  bypass1_in, bypass1_ff;
   logic                  force1_in, force1_ff;

   always_comb begin
      logic [CW-1:0] a;
      logic [CW-1:0] factor;
      a      = req.src_pixel[AI*CW +: CW];
      factor = (req.mode == ppb_pkg::MODE_SOLID) ? a : opacity_ff;
      for (int c = 0; c < NC; c++) begin
         prod1_in[c] = MW'(req.src_pixel[c*CW +: CW]) * MW'(factor);
      end
      image1_in  = (req.mode == ppb_pkg::MODE_IMAGE);
      force1_in  = (req.mode == ppb_pkg::MODE_OPAQUE);
      // transparent source, zero opacity, force opaque and the unused code skip the blend
      unique case (req.mode)
         ppb_pkg::MODE_SOLID: bypass1_in = (a == '0);
         ppb_pkg::MODE_IMAGE: bypass1_in = (a == '0) || (opacity_ff == '0);
         default:             bypass1_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         prod1_ff   <= prod1_in;
         a1_ff      <= req.src_pixel[AI*CW +: CW];
         dst1_ff    <= req.dst_pixel;
         image1_ff  <= image1_in;
         bypass1_ff <= bypass1_in;
         force1_ff  <= force1_in;
      end
   end

   // stage 2: divide down to the premultiplied source, form 255 - alpha
   logic [NC-1:0][CW-1:0] src2_in, src2_ff;
   logic [CW-1:0]         inv2_in, inv2_ff;
   logic [PW-1:0]         dst2_ff;
   logic                  bypass2_ff;
   logic                  force2_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         src2_in[c] = ppb_pkg::div255(prod1_ff[c]);
      end
      if (!image1_ff) begin
         src2_in[AI] = a1_ff;
      end
      inv2_in = ppb_pkg::CHAN_MAX - src2_in[AI];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         src2_ff    <= src2_in;
         inv2_ff    <= inv2_in;
         dst2_ff    <= dst1_ff;
         bypass2_ff <= bypass1_ff;
         force2_ff  <= force1_ff;
      end
   end

   // stage 3: destination channels times 255 - source alpha
   logic [NC-1:0][MW-1:0] prod3_in, prod3_ff;
   logic [NC-1:0][CW-1:0] src3_ff;
   logic [PW-1:0]         dst3_ff;
   logic                  bypass3_ff;
   logic                  force3_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         prod3_in[c] = MW'(dst2_ff[c*CW +: CW]) * MW'(inv2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         prod3_ff   <= prod3_in;
         src3_ff    <= src2_ff;
         dst3_ff    <= dst2_ff;
         bypass3_ff <= bypass2_ff;
         force3_ff  <= force2_ff;
      end
   end

   // stage 4: divide, add, saturate, pick the pass-through cases
   logic [PW-1:0] out_in, out_ff;

   always_comb begin
      logic [CW:0]           sum;
      logic [NC-1:0][CW-1:0] blend;
      for (int c = 0; c < NC; c++) begin
         sum      = {1'b0, src3_ff[c]} + {1'b0, ppb_pkg::div255(prod3_ff[c])};
         blend[c] = sum[CW] ? ppb_pkg::CHAN_MAX : sum[CW-1:0];
      end
      priority if (force3_ff) begin
         out_in = dst3_ff | ppb_pkg::ALPHA_MASK;
      end else if (bypass3_ff) begin
         out_in = dst3_ff;
      end else begin
         out_in = blend;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid     = ctl.valid[3];
   assign rsp.out_pixel = out_ff;

   `PPB_ASSERT_NEXT(opaque_alpha, ctl.load[3] && ctl.valid[2] && force3_ff,
      rsp.out_pixel[PW-1 -: CW] == ppb_pkg::CHAN_MAX, "force opaque beat lost its alpha")
   `PPB_ASSERT_NEXT(pass_through, ctl.load[3] && ctl.valid[2] && bypass3_ff && !force3_ff,
      rsp.out_pixel == $past(dst3_ff), "pass-through beat altered the destination")
   `PPB_ASSERT_NEXT(rsp_hold, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.out_pixel), "stalled rsp beat dropped or changed")

endmodule

// ===== sv/ppb_pipe_ctl.sv =====
`include "premultiplied_pixel_blender_core_macros.svh"

module ppb_pipe_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_ready,
   output logic                  in_ready,
   output ppb_pkg::pipe_ctl_type ctl
);

   localparam int S = ppb_pkg::STAGES;

   logic [S-1:0] valid_ff;
   logic [S-1:0] valid_in;
   logic [S:0]   ready;

   // a stage takes a new beat when empty or when its successor moves
   always_comb begin
      ready[S] = out_ready;
      for (int k = S - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < S; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign ctl.load  = ready[S-1:0];
   assign ctl.valid = valid_ff;

   `PPB_ASSERT_NOW(full_when_blocked, !in_ready, &valid_ff, "input blocked with a free stage")
   `PPB_ASSERT_NEXT(count_up, in_valid && in_ready && !(valid_ff[S-1] && out_ready),
      $countones(valid_ff) == $past($countones(valid_ff)) + 1, "beat lost on entry")
   `PPB_ASSERT_NEXT(count_down, !(in_valid && in_ready) && valid_ff[S-1] && out_ready,
      $countones(valid_ff) + 1 == $past($countones(valid_ff)), "beat invented on exit")

endmodule
